// ===== src/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// shared types and constants of the byte frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned NUM_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned REG_W  = 1;

  localparam logic [REG_W-1:0] REG_HEAD = 1'b0;
  localparam logic [REG_W-1:0] REG_TAIL = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [STAT_W-1:0] ST_SHORT    = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic frame_open;
    logic store;
    logic err_load;
    logic replay_start;
    logic rd_en;
    logic data_load;
    logic idx_next;
    logic good_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic is_head;
    logic is_tail;
    logic frame_err;
    logic out_last;
    logic out_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/bfd_datapath.sv =====
// ----------------------------------------------------------------------------
// bfd_datapath
// frame store, running checksum, replay pointer, result register and counters
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_datapath #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [bfd_pkg::REG_W-1:0]    cfg_index,
  input  wire logic [bfd_pkg::DATA_W-1:0]   cfg_wdata,
  input  wire logic [bfd_pkg::DATA_W-1:0]   rx_byte,
  input  wire bfd_pkg::dp_cmd_t             cmd,
  output bfd_pkg::dp_stat_t                 stat,
  output logic [bfd_pkg::DATA_W-1:0]        out_payload_byte,
  output logic [bfd_pkg::IDX_W-1:0]         out_byte_index,
  output logic [bfd_pkg::STAT_W-1:0]        out_frame_status,
  output logic [bfd_pkg::NUM_W-1:0]         out_frame_number,
  output logic                              out_last
);
  import bfd_pkg::*;

  localparam int unsigned ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned CNT_W  = $clog2(FRAME_BYTES + 1);

  logic [DATA_W-1:0] mem [FRAME_BYTES];

  logic [DATA_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [DATA_W-1:0] sum_r, lastb_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_last_r;
  logic [NUM_W-1:0]  good_r;

  logic              full;
  logic              rd_last;
  logic [STAT_W-1:0] err_code;

  assign full    = (cnt_r == CNT_W'(FRAME_BYTES));
  assign rd_last = ((CNT_W'(rd_idx_r) + CNT_W'(2)) == cnt_r);

  always_comb begin
    if (ovf_r) begin
      err_code = ST_OVERFLOW;
    end else if (cnt_r < CNT_W'(2)) begin
      err_code = ST_SHORT;
    end else if ((sum_r - lastb_r) != lastb_r) begin
      err_code = ST_BAD_SUM;
    end else begin
      err_code = ST_OK;
    end
  end

  assign stat.is_head   = (rx_byte == head_r);
  assign stat.is_tail   = (rx_byte == tail_r);
  assign stat.frame_err = (err_code != ST_OK);
  assign stat.out_last  = out_last_r;
  assign stat.out_ok    = (out_status_r == ST_OK);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= DATA_W'(170);
      tail_r <= DATA_W'(85);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAD: head_r <= cfg_wdata;
        REG_TAIL: tail_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      good_r <= '0;
    end else begin
      if (cmd.frame_open) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (cmd.store) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.good_inc) begin
        good_r <= good_r + NUM_W'(1);
      end
    end
  end

  // running checksum
  always_ff @(posedge clk) begin
    if (cmd.frame_open) begin
      sum_r   <= '0;
      lastb_r <= '0;
    end else if (cmd.store && !full) begin
      sum_r   <= sum_r + rx_byte;
      lastb_r <= rx_byte;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[cnt_r[ADDR_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // replay pointer
  always_ff @(posedge clk) begin
    if (cmd.replay_start) begin
      rd_idx_r <= '0;
    end else if (cmd.idx_next) begin
      rd_idx_r <= rd_idx_r + ADDR_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      out_byte_r   <= '0;
      out_idx_r    <= '0;
      out_status_r <= err_code;
      out_last_r   <= 1'b1;
    end else if (cmd.data_load) begin
      out_byte_r   <= rd_data_r;
      out_idx_r    <= IDX_W'(rd_idx_r);
      out_status_r <= ST_OK;
      out_last_r   <= rd_last;
    end
  end

  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_frame_status = out_status_r;
  assign out_frame_number = good_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ===== src/bfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfd_ctrl
// controller: head hunt, frame capture, replay and result handshake
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire bfd_pkg::dp_stat_t stat,
  output bfd_pkg::dp_cmd_t       cmd
);
  import bfd_pkg::*;

  typedef enum logic [4:0] {
    S_HUNT  = 5'b00001,
    S_FRAME = 5'b00010,
    S_READ  = 5'b00100,
    S_LOAD  = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_xfer, out_xfer;

  assign in_stall  = !((state_r == S_HUNT) || (state_r == S_FRAME));
  assign out_valid = (state_r == S_SEND);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_HUNT: begin
        if (in_xfer && stat.is_head) begin
          cmd.frame_open = 1'b1;
          state_nxt      = S_FRAME;
        end
      end
      S_FRAME: begin
        if (in_xfer) begin
          if (!stat.is_tail) begin
            cmd.store = 1'b1;
          end else if (stat.frame_err) begin
            cmd.err_load = 1'b1;
            state_nxt    = S_SEND;
          end else begin
            cmd.replay_start = 1'b1;
            state_nxt        = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.data_load = 1'b1;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (out_xfer) begin
          if (stat.out_last) begin
            cmd.good_inc = stat.out_ok;
            state_nxt    = S_HUNT;
          end else begin
            cmd.idx_next = 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/byte_frame_deframer_sum_check.sv =====
// ----------------------------------------------------------------------------
// byte_frame_deframer_sum_check
// head/tail framed byte deframer with an 8-bit additive checksum
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while the block hunts for the head
// byte or captures a frame. The tail byte closes the frame: the last stored
// byte must equal the modulo-256 sum of the bytes before it, which is tracked
// as the bytes arrive. A bad frame gives one error transfer, offered in the
// cycle after the tail. A good frame is replayed: a frame store read, result
// load and result transfer per payload byte, the transfer held by any output
// stall; input is stalled for the whole replay. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_frame_deframer_sum_check #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bfd_pkg::REG_W-1:0]     cfg_index,
  input  wire logic [bfd_pkg::DATA_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bfd_pkg::DATA_W-1:0]    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bfd_pkg::DATA_W-1:0]         out_payload_byte,
  output logic [bfd_pkg::IDX_W-1:0]          out_byte_index,
  output logic [bfd_pkg::STAT_W-1:0]         out_frame_status,
  output logic [bfd_pkg::NUM_W-1:0]          out_frame_number,
  output logic                               out_last
);
  import bfd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfd_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .rx_byte          (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_status (out_frame_status),
    .out_frame_number (out_frame_number),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== dv/tb_byte_frame_deframer_sum_check.sv =====
// ----------------------------------------------------------------------------
// tb_byte_frame_deframer_sum_check
// self-checking testbench for the byte frame deframer
// ----------------------------------------------------------------------------
// A short table of bytes covers runt frames, a bad checksum, the head byte
// inside a frame and bytes outside a frame; error rows carry their expected
// transfer typed in. Random framed traffic then runs under several head and
// tail settings (extremes, head equal to tail), with long frames reaching the
// full store and overflow. Every output transfer is checked against its
// typed-in value or an in-bench prediction of the deframer. Both sides idle
// in short random bursts except in the final phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_byte_frame_deframer_sum_check;

  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;

  localparam int FRAME_BYTES = 32;
  localparam int STUCK_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [IDX_W-1:0]  idx;
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  number;
    logic              last;
  } frame_result_t;

  typedef struct packed {
    logic [DATA_W-1:0] rx;
    logic              typed;
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  number;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [REG_W-1:0]    cfg_index = REG_HEAD;
  logic [DATA_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [DATA_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DATA_W-1:0]   out_payload_byte;
  logic [IDX_W-1:0]    out_byte_index;
  logic [STAT_W-1:0]   out_frame_status;
  logic [NUM_W-1:0]    out_frame_number;
  logic                out_last;

  logic                quiet = 1'b0;
  int                  stall_left = 0;
  int                  stuck_cycles = 0;
  int                  mismatch_count = 0;
  int                  bytes_sent = 0;

  // deframer prediction state
  logic [DATA_W-1:0]   head_cfg = 8'hAA;
  logic [DATA_W-1:0]   tail_cfg = 8'h55;
  logic                frm_open = 1'b0;
  logic [DATA_W-1:0]   frm_store [FRAME_BYTES];
  int                  frm_count = 0;
  logic                frm_overflow = 1'b0;
  logic [NUM_W-1:0]    frm_good = '0;

  frame_result_t       awaited_transfers [$];

  directed_row_t directed_rows [25] = '{
    '{8'h00, 1'b0, ST_OK,       16'd0},
    '{8'hFF, 1'b0, ST_OK,       16'd0},
    '{8'hAA, 1'b0, ST_OK,       16'd0},
    '{8'h55, 1'b1, ST_SHORT,    16'd0},
    '{8'hAA, 1'b0, ST_OK,       16'd0},
    '{8'h07, 1'b0, ST_OK,       16'd0},
    '{8'h55, 1'b1, ST_SHORT,    16'd0},
    '{8'hAA, 1'b0, ST_OK,       16'd0},
    '{8'hFF, 1'b0, ST_OK,       16'd0},
    '{8'h01, 1'b0, ST_OK,       16'd0},
    '{8'h55, 1'b1, ST_BAD_SUM,  16'd0},
    '{8'hAA, 1'b0, ST_OK,       16'd0},
    '{8'hFF, 1'b0, ST_OK,       16'd0},
    '{8'hAA, 1'b0, ST_OK,       16'd0},
    '{8'hA9, 1'b0, ST_OK,       16'd0},
    '{8'h55, 1'b0, ST_OK,       16'd0},
    '{8'hAA, 1'b0, ST_OK,       16'd0},
    '{8'h00, 1'b0, ST_OK,       16'd0},
    '{8'h00, 1'b0, ST_OK,       16'd0},
    '{8'h55, 1'b0, ST_OK,       16'd0},
    '{8'hAA, 1'b0, ST_OK,       16'd0},
    '{8'h80, 1'b0, ST_OK,       16'd0},
    '{8'h55, 1'b1, ST_SHORT,    16'd2},
    '{8'h55, 1'b0, ST_OK,       16'd0},
    '{8'h00, 1'b0, ST_OK,       16'd0}
  };

  byte_frame_deframer_sum_check #(
    .FRAME_BYTES (FRAME_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_status (out_frame_status),
    .out_frame_number (out_frame_number),
    .out_last         (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  // drive one byte, wait for the transfer, then predict its results
  task automatic put_byte(input logic [DATA_W-1:0] b, input logic typed = 1'b0,
                          input logic [STAT_W-1:0] t_status = ST_OK,
                          input logic [NUM_W-1:0] t_number = '0);
    frame_result_t found [$];
    frame_result_t r;
    logic [DATA_W-1:0] sum;
    int plen;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;

    r = '0;
    r.number = frm_good;
    r.last   = 1'b1;
    if (!frm_open) begin
      if (b == head_cfg) begin
        frm_open     = 1'b1;
        frm_count    = 0;
        frm_overflow = 1'b0;
      end
    end else if (b != tail_cfg) begin
      if (frm_count < FRAME_BYTES) begin
        frm_store[frm_count] = b;
        frm_count++;
      end else begin
        frm_overflow = 1'b1;
      end
    end else begin
      frm_open = 1'b0;
      if (frm_overflow) begin
        r.status = ST_OVERFLOW;
        found.push_back(r);
      end else if (frm_count < 2) begin
        r.status = ST_SHORT;
        found.push_back(r);
      end else begin
        plen = frm_count - 1;
        sum  = '0;
        for (int i = 0; i < plen; i++) sum += frm_store[i];
        if (sum != frm_store[plen]) begin
          r.status = ST_BAD_SUM;
          found.push_back(r);
        end else begin
          for (int i = 0; i < plen; i++) begin
            r.payload = frm_store[i];
            r.idx     = IDX_W'(i);
            r.status  = ST_OK;
            r.last    = (i == plen - 1);
            found.push_back(r);
          end
          frm_good++;
        end
      end
    end

    if (typed) begin
      r = '0;
      r.status = t_status;
      r.number = t_number;
      r.last   = 1'b1;
      awaited_transfers.push_back(r);
    end else begin
      foreach (found[i]) awaited_transfers.push_back(found[i]);
    end
  endtask

  // hold the sender until every awaited transfer has arrived, then let it settle
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (awaited_transfers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_framing(input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] t);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEAD;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= REG_TAIL;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we   <= 1'b0;
    head_cfg = h;
    tail_cfg = t;
  endtask

  function automatic logic [DATA_W-1:0] body_byte();
    logic [DATA_W-1:0] v;
    v = DATA_W'($urandom_range(0, 255));
    while (v == tail_cfg) v = DATA_W'($urandom_range(0, 255));
    return v;
  endfunction

  task automatic send_frame(input int len, input logic good_sum);
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] b;
    sum = '0;
    put_byte(head_cfg);
    for (int i = 0; i < len; i++) begin
      b = body_byte();
      sum += b;
      put_byte(b);
    end
    if (!good_sum) sum ^= DATA_W'($urandom_range(1, 255));
    put_byte(sum);
    // now and then the tail goes missing and the next frame runs on
    if (quiet || $urandom_range(0, 11) != 0) put_byte(tail_cfg);
  endtask

  task automatic run_traffic(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) put_byte(DATA_W'($urandom_range(0, 255)));
      end
      send_frame(($urandom_range(0, 15) == 0) ? int'($urandom_range(29, 33))
                                              : int'($urandom_range(0, 6)),
                 $urandom_range(0, 4) != 0);
    end
  endtask

  // output side idling
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_out
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_transfers.size() == 0) begin
        report_mismatch("transfer with nothing awaited", 32'(out_payload_byte), 0);
      end else begin
        want = awaited_transfers.pop_front();
        if (out_payload_byte !== want.payload)
          report_mismatch("payload_byte", 32'(out_payload_byte), 32'(want.payload));
        if (out_byte_index !== want.idx)
          report_mismatch("byte_index", 32'(out_byte_index), 32'(want.idx));
        if (out_frame_status !== want.status)
          report_mismatch("frame_status", 32'(out_frame_status), 32'(want.status));
        if (out_frame_number !== want.number)
          report_mismatch("frame_number", 32'(out_frame_number), 32'(want.number));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("byte_frame_deframer_sum_check regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      put_byte(directed_rows[i].rx, directed_rows[i].typed,
               directed_rows[i].status, directed_rows[i].number);
    end

    settle_idle();
    set_framing(8'h00, 8'hFF);
    send_frame(31, 1'b1);
    send_frame(32, 1'b1);
    run_traffic(23);

    settle_idle();
    set_framing(8'hFF, 8'h00);
    run_traffic(23);

    settle_idle();
    set_framing(8'h3C, 8'h3C);
    run_traffic(23);

    settle_idle();
    set_framing(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
    run_traffic(23);

    settle_idle();
    quiet <= 1'b1;
    set_framing(8'hAA, 8'h55);
    run_traffic(23);

    settle_idle();
    if (mismatch_count == 0) begin
      $display("byte_frame_deframer_sum_check regression: pass");
    end else begin
      $display("byte_frame_deframer_sum_check regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/bfd_pkg.sv
src/bfd_datapath.sv
src/bfd_ctrl.sv
src/byte_frame_deframer_sum_check.sv
dv/tb_byte_frame_deframer_sum_check.sv
